// ===== hw/rtl/evs_pkg.sv =====
package evs_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;
    localparam int ENERGY_W    = 43;
    localparam int THRESH_W    = 31;
    localparam int COUNT_W     = 20;
    localparam int OUT_CNT_W   = 7;
    localparam int CFG_INDEX_W = 2;

    // defaults for the module parameters
    localparam int DEF_MAX_CHUNK_SAMPLES = 4096;
    localparam int DEF_MAX_HELD_CHUNKS   = 64;

    // depth of the event queue between front and back
    localparam int EVENT_QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET    = THRESH_W'(160000);
    localparam logic [COUNT_W-1:0]  PAUSE_RESET     = COUNT_W'(8000);
    localparam logic [COUNT_W-1:0]  MAX_UTTER_RESET = COUNT_W'(96000);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAUSE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_UTTER = 2'd2;

    // per-result chunk status
    typedef enum logic [1:0] {
        STATUS_DROPPED = 2'd0,
        STATUS_SILENCE = 2'd1,
        STATUS_SPEECH  = 2'd2,
        STATUS_FINISH  = 2'd3
    } chunk_status_t;

    // configuration as seen by the back part
    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [COUNT_W-1:0]  pause;
        logic [COUNT_W-1:0]  max_utter;
    } cfg_t;

endpackage

// ===== hw/rtl/evs_fifo.sv =====
module evs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = evs_pkg::EVENT_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/evs_front.sv =====
module evs_front #(
    parameter int MAX_CHUNK_SAMPLES = evs_pkg::DEF_MAX_CHUNK_SAMPLES,
    parameter int CW = $clog2(MAX_CHUNK_SAMPLES + 1),
    parameter int EV_W = 1 + evs_pkg::ENERGY_W + CW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [evs_pkg::SAMPLE_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [EV_W-1:0]               q_data
);

    localparam int EW = evs_pkg::ENERGY_W;

    logic                          s0_valid_reg;
    logic [evs_pkg::SQUARE_W-1:0]  s0_sq_reg;
    logic                          s0_last_reg;
    logic                          s0_finish_reg;
    logic [EW-1:0]                 energy_reg, energy_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;

    logic                          s0_event;
    logic                          s0_fire;
    logic                          accept;
    logic signed [31:0]            product;
    logic [EW:0]                   sum_wide;
    logic [EW-1:0]                 energy_acc;
    logic [CW-1:0]                 cnt_acc;

    assign accept   = s_tvalid && s_tready;
    assign s0_event = s0_last_reg || s0_finish_reg;
    assign s0_fire  = s0_valid_reg && (!s0_event || !q_full);
    assign s_tready = !s0_valid_reg || s0_fire;

    // square of the incoming sample
    assign product = $signed(s_tdata) * $signed(s_tdata);

    // saturating accumulate, samples past the chunk limit are ignored
    always_comb
    begin
        sum_wide   = {1'b0, energy_reg} + (EW + 1)'(s0_sq_reg);
        energy_acc = energy_reg;
        cnt_acc    = cnt_reg;
        if (cnt_reg < CW'(MAX_CHUNK_SAMPLES))
        begin
            energy_acc = sum_wide[EW] ? {EW{1'b1}} : sum_wide[EW-1:0];
            cnt_acc    = cnt_reg + 1'b1;
        end
    end

    // chunk closing and event generation
    always_comb
    begin
        energy_next = energy_reg;
        cnt_next    = cnt_reg;
        q_push      = 1'b0;
        q_data      = {1'b0, energy_acc, cnt_acc};
        if (s0_fire)
        begin
            if (s0_finish_reg)
            begin
                q_push      = 1'b1;
                q_data      = {1'b1, {EW{1'b0}}, {CW{1'b0}}};
                energy_next = '0;
                cnt_next    = '0;
            end
            else if (s0_last_reg)
            begin
                q_push      = 1'b1;
                energy_next = '0;
                cnt_next    = '0;
            end
            else
            begin
                energy_next = energy_acc;
                cnt_next    = cnt_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s0_last_reg   <= 1'b0;
            s0_finish_reg <= 1'b0;
            energy_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
            cnt_reg    <= cnt_next;
            if (accept)
            begin
                s0_valid_reg  <= 1'b1;
                s0_last_reg   <= s_tlast;
                s0_finish_reg <= s_tuser;
            end
            else if (s0_fire)
            begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    // sample square, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_sq_reg <= product[evs_pkg::SQUARE_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/evs_back.sv =====
module evs_back #(
    parameter int MAX_CHUNK_SAMPLES = evs_pkg::DEF_MAX_CHUNK_SAMPLES,
    parameter int MAX_HELD_CHUNKS = evs_pkg::DEF_MAX_HELD_CHUNKS,
    parameter int CW = $clog2(MAX_CHUNK_SAMPLES + 1),
    parameter int EV_W = 1 + evs_pkg::ENERGY_W + CW
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  evs_pkg::cfg_t                   cfg,
    input  logic                            q_empty,
    input  logic [EV_W-1:0]                 q_data,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser
);

    localparam int EW   = evs_pkg::ENERGY_W;
    localparam int TW   = evs_pkg::THRESH_W;
    localparam int NW   = evs_pkg::COUNT_W;
    localparam int OW   = evs_pkg::OUT_CNT_W;
    localparam int PW   = TW + CW;
    localparam int CMPW = (PW > EW) ? PW : EW;
    localparam int SW   = ((CW > NW) ? CW : NW) + 1;
    localparam int HW   = $clog2(MAX_HELD_CHUNKS + 1);
    localparam int LW   = $clog2(MAX_HELD_CHUNKS);
    localparam int KW   = (HW + 1 > OW) ? HW + 1 : OW;

    // product stage
    logic              s1_valid_reg;
    logic              s1_finish_reg;
    logic [EW-1:0]     s1_energy_reg;
    logic [CW-1:0]     s1_n_reg;
    logic [PW-1:0]     s1_prod_reg;

    // utterance state
    logic [HW-1:0]     held_reg, held_next;
    logic [LW-1:0]     last_idx_reg, last_idx_next;
    logic [NW-1:0]     utt_reg, utt_next;
    logic [NW-1:0]     sil_reg, sil_next;
    logic              seen_reg, seen_next;

    // output register
    logic                   out_valid_reg;
    evs_pkg::chunk_status_t out_status_reg, out_status_next;
    logic                   out_seg_reg, out_seg_next;
    logic [OW-1:0]          out_keep_reg, out_keep_next;
    logic [OW-1:0]          out_utt_reg, out_utt_next;

    logic              s2_fire;
    logic              q_finish;
    logic [CW-1:0]     q_n;
    logic [EW-1:0]     q_energy;
    logic              speech;
    logic [HW-1:0]     held_inc;
    logic [LW-1:0]     last_upd;
    logic [SW-1:0]     sil_sum;
    logic [SW-1:0]     utt_sum;
    logic [NW-1:0]     sil_upd;
    logic [NW-1:0]     utt_upd;
    logic              seen_upd;
    logic [KW-1:0]     keep_lim;
    logic [KW-1:0]     keep_held;
    logic [KW-1:0]     keep_cur;
    logic [KW-1:0]     keep_upd;

    assign {q_finish, q_energy, q_n} = q_data;

    assign s2_fire = s1_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop   = !q_empty && (!s1_valid_reg || s2_fire);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_seg_reg;
    assign m_tdata  = {2'b00, out_utt_reg, out_keep_reg};

    // speech decision on the registered threshold product
    assign speech = CMPW'(s1_energy_reg) > CMPW'(s1_prod_reg);

    // keep count with the current state, used on finish
    assign keep_lim  = KW'(last_idx_reg) + KW'(2);
    assign keep_held = KW'(held_reg);
    assign keep_cur  = (keep_held < keep_lim) ? keep_held : keep_lim;

    // state update for an appended chunk
    always_comb
    begin
        held_inc = (held_reg < HW'(MAX_HELD_CHUNKS)) ? held_reg + 1'b1 : held_reg;
        last_upd = last_idx_reg;
        seen_upd = seen_reg;
        sil_sum  = SW'(sil_reg) + SW'(s1_n_reg);
        utt_sum  = SW'(utt_reg) + SW'(s1_n_reg);
        utt_upd  = (utt_sum > SW'({NW{1'b1}})) ? {NW{1'b1}} : utt_sum[NW-1:0];
        sil_upd  = (sil_sum > SW'({NW{1'b1}})) ? {NW{1'b1}} : sil_sum[NW-1:0];
        if (speech)
        begin
            last_upd = LW'(held_inc - 1'b1);
            seen_upd = 1'b1;
            sil_upd  = '0;
        end
        keep_upd = (KW'(held_inc) < KW'(last_upd) + KW'(2)) ?
                   KW'(held_inc) : KW'(last_upd) + KW'(2);
    end

    // result and next utterance state
    always_comb
    begin
        held_next       = held_reg;
        last_idx_next   = last_idx_reg;
        utt_next        = utt_reg;
        sil_next        = sil_reg;
        seen_next       = seen_reg;
        out_status_next = evs_pkg::STATUS_DROPPED;
        out_seg_next    = 1'b0;
        out_keep_next   = '0;
        out_utt_next    = '0;
        priority if (s1_finish_reg)
        begin
            out_status_next = evs_pkg::STATUS_FINISH;
            out_seg_next    = seen_reg;
            out_keep_next   = seen_reg ? keep_cur[OW-1:0] : '0;
            held_next       = '0;
            last_idx_next   = '0;
            utt_next        = '0;
            sil_next        = '0;
            seen_next       = 1'b0;
        end
        else if (held_reg == '0 && !speech)
        begin
            out_status_next = evs_pkg::STATUS_DROPPED;
        end
        else
        begin
            out_status_next = speech ? evs_pkg::STATUS_SPEECH : evs_pkg::STATUS_SILENCE;
            if (seen_upd && (sil_upd >= cfg.pause || utt_upd >= cfg.max_utter))
            begin
                out_seg_next  = 1'b1;
                out_keep_next = keep_upd[OW-1:0];
                held_next     = '0;
                last_idx_next = '0;
                utt_next      = '0;
                sil_next      = '0;
                seen_next     = 1'b0;
            end
            else
            begin
                out_utt_next  = OW'(held_inc);
                held_next     = held_inc;
                last_idx_next = last_upd;
                utt_next      = utt_upd;
                sil_next      = sil_upd;
                seen_next     = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_finish_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            last_idx_reg  <= '0;
            utt_reg       <= '0;
            sil_reg       <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg  <= 1'b1;
                s1_finish_reg <= q_finish;
            end
            else if (s2_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
                last_idx_reg  <= last_idx_next;
                utt_reg       <= utt_next;
                sil_reg       <= sil_next;
                seen_reg      <= seen_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_energy_reg <= q_energy;
            s1_n_reg      <= q_n;
            s1_prod_reg   <= PW'(cfg.threshold) * PW'(q_n);
        end
        if (s2_fire)
        begin
            out_status_reg <= out_status_next;
            out_seg_reg    <= out_seg_next;
            out_keep_reg   <= out_keep_next;
            out_utt_reg    <= out_utt_next;
        end
    end

endmodule

// ===== hw/rtl/energy_vad_segmenter.sv =====
// Energy-threshold voice activity segmenter. Takes one signed 16-bit mono sample
// per cycle on s_* when not stalled (s_tlast closes a chunk, s_tuser is finish)
// and gives one result per chunk end or finish on m_*: m_tuser is the chunk status,
// m_tlast marks an utterance end, m_tdata holds keep_chunks and utterance_chunks.
// A chunk is speech when its energy sum exceeds threshold * samples. The front
// squares and accumulates each sample at one sample per clock unless stalled;
// closed chunks and finishes go through a 4-entry queue to the back, which
// multiplies the threshold by the chunk length in one stage and updates the
// utterance in the next, one chunk per clock unless m_tready stalls it. A result
// passes the front register, the queue, the product stage and the output register.
// Registers are to be written on the cfg_* channel only while the block is idle,
// a rule for the user that the block does not enforce; they apply from the next chunk.
module energy_vad_segmenter #(
    parameter int MAX_CHUNK_SAMPLES = evs_pkg::DEF_MAX_CHUNK_SAMPLES,
    parameter int MAX_HELD_CHUNKS   = evs_pkg::DEF_MAX_HELD_CHUNKS
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[15:0]
    input  logic        s_tlast,   // chunk_last
    input  logic        s_tuser,   // finish
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // keep_chunks[6:0], utterance_chunks[13:7], zero
    output logic        m_tlast,   // segment_end
    output logic [1:0]  m_tuser,   // chunk_status[1:0]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int CW   = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int EV_W = 1 + evs_pkg::ENERGY_W + CW;
    localparam int NW   = evs_pkg::COUNT_W;

    evs_pkg::cfg_t    cfg_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [EV_W-1:0]  q_wdata;
    logic [EV_W-1:0]  q_rdata;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= evs_pkg::THRESH_RESET;
            cfg_reg.pause     <= evs_pkg::PAUSE_RESET;
            cfg_reg.max_utter <= evs_pkg::MAX_UTTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                evs_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_data;
                evs_pkg::REG_PAUSE:     cfg_reg.pause     <= cfg_data[NW-1:0];
                evs_pkg::REG_MAX_UTTER: cfg_reg.max_utter <= cfg_data[NW-1:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    evs_front #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
        .CW                (CW),
        .EV_W              (EV_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    evs_fifo #(
        .WIDTH (EV_W),
        .DEPTH (evs_pkg::EVENT_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_data (q_rdata)
    );

    evs_back #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
        .MAX_HELD_CHUNKS   (MAX_HELD_CHUNKS),
        .CW                (CW),
        .EV_W              (EV_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // write to the unused register slot, which must have no effect
    localparam logic [evs_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int          CHUNK_CAP      = evs_pkg::DEF_MAX_CHUNK_SAMPLES;
    localparam int          HELD_CAP       = evs_pkg::DEF_MAX_HELD_CHUNKS;
    localparam bit [42:0]   ENERGY_FULL    = '1;
    localparam bit [19:0]   COUNT_FULL     = '1;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          IDLE_LIMIT     = 2000;
    localparam int          SINK_HOLD      = 400;
    localparam int          HOLD_AFTER     = 40;

    typedef struct packed {
        evs_pkg::chunk_status_t status;
        bit                     seg_end;
        bit [6:0]               keep;
        bit [6:0]               held;
    } vad_result_t;

    // tracks the utterance state and the results still owed by the block
    class segment_tracker;
        bit [30:0]   threshold;
        bit [19:0]   pause_len;
        bit [19:0]   max_len;
        bit [42:0]   energy;
        bit [12:0]   chunk_len;
        bit [6:0]    held;
        bit [5:0]    speech_idx;
        bit [19:0]   utter_len;
        bit [19:0]   silence_len;
        bit          speech_seen;
        vad_result_t expected_q[$];
        int          errors;
        int          results_checked;
        int          speech_chunks;
        int          segments;
        int          finishes;

        function new();
            threshold   = evs_pkg::THRESH_RESET;
            pause_len   = evs_pkg::PAUSE_RESET;
            max_len     = evs_pkg::MAX_UTTER_RESET;
            energy      = '0;
            chunk_len   = '0;
            clear_utterance();
        endfunction

        function void clear_utterance();
            held        = '0;
            speech_idx  = '0;
            utter_len   = '0;
            silence_len = '0;
            speech_seen = 1'b0;
        endfunction

        function bit [6:0] keep_now();
            int lim;
            lim = int'(speech_idx) + 2;
            return (int'(held) < lim) ? held : 7'(lim);
        endfunction

        function bit [19:0] add_capped(bit [19:0] a, bit [12:0] b);
            bit [20:0] s;
            s = {1'b0, a} + 21'(b);
            return (s > 21'(COUNT_FULL)) ? COUNT_FULL : s[19:0];
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] data);
            case (idx)
                evs_pkg::REG_THRESHOLD: threshold = data;
                evs_pkg::REG_PAUSE:     pause_len = data[19:0];
                evs_pkg::REG_MAX_UTTER: max_len = data[19:0];
                default: ;
            endcase
        endfunction

        // one accepted sample request; queues the result it causes, if any
        function void note_request(logic [15:0] smp, bit last, bit fin);
            vad_result_t r;
            int          mag;
            bit [43:0]   acc;
            bit [12:0]   n;
            bit          speech;
            r = '{evs_pkg::STATUS_DROPPED, 1'b0, 7'd0, 7'd0};
            // finish wins over everything, partial chunk is thrown away
            if (fin)
            begin
                r.status  = evs_pkg::STATUS_FINISH;
                r.seg_end = speech_seen;
                r.keep    = speech_seen ? keep_now() : 7'd0;
                energy    = '0;
                chunk_len = '0;
                clear_utterance();
                expected_q = {expected_q, r};
                return;
            end
            // square-accumulate, samples past the chunk cap are ignored
            if (chunk_len < 13'(CHUNK_CAP))
            begin
                mag = $signed(smp);
                if (mag < 0)
                    mag = -mag;
                acc = {1'b0, energy} + 44'(mag * mag);
                energy = (acc > 44'(ENERGY_FULL)) ? ENERGY_FULL : acc[42:0];
                chunk_len++;
            end
            if (!last)
                return;
            // chunk close: exact compare against threshold times length
            n = chunk_len;
            speech = 64'(energy) > 64'(threshold) * 64'(n);
            energy = '0;
            chunk_len = '0;
            if (held != 0 || speech)
            begin
                r.status = speech ? evs_pkg::STATUS_SPEECH : evs_pkg::STATUS_SILENCE;
                if (held < 7'(HELD_CAP))
                    held++;
                if (speech)
                begin
                    speech_idx  = 6'(held - 7'd1);
                    speech_seen = 1'b1;
                    silence_len = '0;
                end
                else
                    silence_len = add_capped(silence_len, n);
                utter_len = add_capped(utter_len, n);
                if (speech_seen && (silence_len >= pause_len || utter_len >= max_len))
                begin
                    r.seg_end = 1'b1;
                    r.keep    = keep_now();
                    clear_utterance();
                end
            end
            r.held = held;
            expected_q = {expected_q, r};
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(evs_pkg::chunk_status_t status, bit seg_end, bit [6:0] keep,
                          bit [6:0] held_now);
            vad_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %s", status.name()));
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            if (exp_r.status == evs_pkg::STATUS_SPEECH)
                speech_chunks++;
            if (exp_r.status == evs_pkg::STATUS_FINISH)
                finishes++;
            if (exp_r.seg_end)
                segments++;
            if (status != exp_r.status)
                report_mismatch($sformatf("result %0d status %s, expected %s",
                    results_checked, status.name(), exp_r.status.name()));
            if (seg_end != exp_r.seg_end)
                report_mismatch($sformatf("result %0d segment_end %0b, expected %0b",
                    results_checked, seg_end, exp_r.seg_end));
            if (keep != exp_r.keep)
                report_mismatch($sformatf("result %0d keep_chunks %0d, expected %0d",
                    results_checked, keep, exp_r.keep));
            if (held_now != exp_r.held)
                report_mismatch($sformatf("result %0d utterance_chunks %0d, expected %0d",
                    results_checked, held_now, exp_r.held));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = evs_pkg::REG_THRESHOLD;
    logic [30:0] cfg_data  = '0;

    segment_tracker sb = new();
    int items_sent;
    int idle_cycles;
    bit src_calm;

    energy_vad_segmenter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [15:0] smp, input bit last, input bit fin);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        s_tuser  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(smp, last, fin);
        items_sent++;
    endtask

    // one chunk; a broken chunk is cut off by a finish instead of tlast
    task automatic send_chunk(input int len, input bit loud, input int bound,
                              input bit broken);
        logic [15:0] smp;
        for (int i = 0; i < len; i++)
        begin
            if (loud)
                smp = 16'($urandom);
            else
                smp = 16'(int'($urandom_range(0, 2 * bound)) - bound);
            send_item(smp, !broken && (i == len - 1), 1'b0);
        end
        if (broken)
            send_item(16'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_random(input int count, input int quiet_bound);
        int stop_at;
        int len;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 24) == 0)
                src_calm = !src_calm;
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(16'($urandom), 1'($urandom), 1'b1);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    len = $urandom_range(1, 4);
                else if (r < 97)
                    len = $urandom_range(5, 24);
                else
                    len = $urandom_range(25, 120);
                send_chunk(len, $urandom_range(0, 99) < 45, quiet_bound,
                           $urandom_range(0, 99) < 4);
            end
        end
    endtask

    // stop offering and wait until every owed result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [30:0] thr, input logic [30:0] pause_d,
                                 input logic [30:0] max_d, input bit poke_unused);
        logic [1:0]  idx [4] = '{evs_pkg::REG_THRESHOLD, evs_pkg::REG_PAUSE,
                                 evs_pkg::REG_MAX_UTTER, REG_UNUSED};
        logic [30:0] vals [4];
        vals = '{thr, pause_d, max_d, 31'($urandom)};
        for (int i = 0; i < (poke_unused ? 4 : 3); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        int  gap;
        bit  calm;
        bit  held_off;
        calm     = 1'b0;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            if (!held_off && sb.results_checked >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
            end
            gap = pick_gap(calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(evs_pkg::chunk_status_t'(m_tuser), m_tlast, m_tdata[6:0],
                            m_tdata[13:7]);
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("energy_vad_segmenter verification failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every status, finish corner cases
        load_settings(evs_pkg::THRESH_RESET, 31'd2, 31'd1000, 1'b0);
        send_item(16'd0, 1'b0, 1'b0);
        send_item(16'd0, 1'b1, 1'b0);              // silence before speech dropped
        send_item(16'h7fff, 1'b0, 1'b0);
        send_item(16'h8000, 1'b1, 1'b0);           // speech
        send_item(16'd1, 1'b1, 1'b0);              // silence appended
        send_item(16'hffff, 1'b0, 1'b0);
        send_item(16'd0, 1'b1, 1'b0);              // pause reached, segment ends
        send_item(16'd400, 1'b1, 1'b0);            // energy equal to threshold: silence
        send_item(16'd401, 1'b1, 1'b0);            // just above: speech
        send_item(16'd5, 1'b0, 1'b0);
        send_item(16'd0, 1'b0, 1'b1);              // finish mid-chunk
        send_item(16'd0, 1'b0, 1'b1);              // finish with nothing held
        send_item(16'h8000, 1'b1, 1'b0);
        send_item(16'd12345, 1'b1, 1'b1);          // finish and tlast together
        send_item(16'h5555, 1'b0, 1'b0);
        send_item(16'haaaa, 1'b1, 1'b0);
        send_item(16'h0001, 1'b1, 1'b0);
        send_item(16'h7fff, 1'b0, 1'b1);
        drain();

        // near the default threshold, short pause and length limit
        load_settings(31'd160000, 31'd24, 31'd300, 1'b0);
        run_random(250, 600);
        drain();
        run_random(200, 600);
        drain();

        // zero threshold and zero pause: every appended chunk ends a segment
        load_settings(31'd0, {11'($urandom), 20'd0}, {11'($urandom), COUNT_FULL}, 1'b0);
        run_random(200, 0);
        drain();

        // top threshold never passes, zero length limit, unused slot poked
        load_settings(31'h4000_0000, 31'(COUNT_FULL), 31'd0, 1'b1);
        run_random(100, 32767);
        drain();

        // long utterance: chunk count saturation
        load_settings(31'd1, 31'(COUNT_FULL), 31'(COUNT_FULL), 1'b0);
        for (int i = 0; i < HELD_CAP + 16; i++)
            send_chunk(1, $urandom_range(0, 9) < 7, 0, 1'b0);
        send_item(16'd0, 1'b0, 1'b1);
        run_random(200, 0);
        drain();

        // random settings
        for (int p = 0; p < 4; p++)
        begin
            load_settings(31'($urandom_range(0, 1 << 21)),
                          {11'($urandom), 20'($urandom_range(1, 300))},
                          {11'($urandom), 20'($urandom_range(1, 3000))}, 1'b0);
            run_random(150, $urandom_range(0, 2000));
            drain();
        end

        $display("run covered %0d sample requests and %0d results", items_sent,
                 sb.results_checked);
        $display("  %0d speech chunks, %0d segment ends, %0d finishes, %0d mismatches",
                 sb.speech_chunks, sb.segments, sb.finishes, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("energy_vad_segmenter verification clean");
        else
            $display("energy_vad_segmenter verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/evs_pkg.sv
hw/rtl/evs_fifo.sv
hw/rtl/evs_front.sv
hw/rtl/evs_back.sv
hw/rtl/energy_vad_segmenter.sv
tb/sv/tb.sv
